FILE: rtl/kmd_pkg.sv
// Package for the keypad matrix debounce scanner.
// Holds the default sizes, the counter width, and the command and status
// structs passed between the controller and the datapath. No dependencies.
package kmd_pkg;

  // Default matrix size.
  localparam int NUM_COLUMNS_DEF = 6;
  localparam int NUM_ROWS_DEF    = 6;

  // Debounce counter width and the limit loaded at reset.
  localparam int             CNT_W     = 8;
  localparam logic [CNT_W-1:0] LIMIT_RST = 8'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // Store a beat's row levels and advance the column pointer.
    logic rd;          // Read the counter of the selected key.
    logic commit;      // Write back the updated counter and debounced state.
    logic emit_pend;   // Move the pending press into the result register.
    logic emit_final;  // Load the closing result of the tick.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rise;        // The selected key's debounced state rises on update.
    logic pend_vld;    // A press is waiting to be emitted.
    logic out_free;    // The result register can take a new beat this cycle.
  } sts_t;

endpackage

FILE: rtl/kmd_ctrl.sv
// Controller of the keypad matrix debounce scanner.
// Walks all keys one at a time and sequences reads, updates and result beats.
// Depends on kmd_pkg.
module kmd_ctrl #(
  parameter int NUM_COLUMNS = kmd_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = kmd_pkg::NUM_ROWS_DEF,
  localparam int NK = NUM_COLUMNS * NUM_ROWS,
  localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1,
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int KW = (NK > 1) ? $clog2(NK) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  kmd_pkg::sts_t  sts,
  output kmd_pkg::cmd_t  cmd,
  output logic [CW-1:0]  key_col,
  output logic [RW-1:0]  key_row,
  output logic [KW-1:0]  key_idx
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic          blocked;

  assign in_stall = (state_r != S_IDLE);
  assign key_col  = col_r;
  assign key_row  = row_r;
  assign key_idx  = key_r;

  // An update that finds a new press while one is pending needs the result slot.
  assign blocked = sts.rise && sts.pend_vld && !sts.out_free;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    key_nxt        = key_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          col_nxt    = '0;
          row_nxt    = '0;
          key_nxt    = '0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!blocked) begin
          cmd.commit    = 1'b1;
          cmd.emit_pend = sts.rise && sts.pend_vld;
          if (key_r == KW'(NK - 1)) begin
            state_nxt = S_FIN;
          end else begin
            key_nxt = key_r + KW'(1);
            if (row_r == RW'(NUM_ROWS - 1)) begin
              row_nxt = '0;
              col_nxt = col_r + CW'(1);
            end else begin
              row_nxt = row_r + RW'(1);
            end
            state_nxt = S_READ;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and key indices.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      key_r   <= key_nxt;
    end
  end

endmodule

FILE: rtl/kmd_dpath.sv
// Datapath of the keypad matrix debounce scanner.
// Holds raw samples, the counter memory, debounced states, the pending press
// and the result register. Depends on kmd_pkg.
module kmd_dpath #(
  parameter int NUM_COLUMNS = kmd_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = kmd_pkg::NUM_ROWS_DEF,
  localparam int NK = NUM_COLUMNS * NUM_ROWS,
  localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1,
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int KW = (NK > 1) ? $clog2(NK) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kmd_pkg::cmd_t             cmd,
  output kmd_pkg::sts_t             sts,
  input  logic [CW-1:0]             key_col,
  input  logic [RW-1:0]             key_row,
  input  logic [KW-1:0]             key_idx,
  input  logic [NUM_ROWS-1:0]       in_row_levels,
  input  logic                      cfg_we,
  input  logic [kmd_pkg::CNT_W-1:0] cfg_limit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CW-1:0]             out_next_column,
  output logic                      out_press_valid,
  output logic [CW-1:0]             out_press_column,
  output logic [RW-1:0]             out_press_row,
  output logic                      out_last
);

  localparam int CNT_W = kmd_pkg::CNT_W;

  // Configuration and column pointer.
  logic [CNT_W-1:0]    lim_r;
  logic [CW-1:0]       ptr_r, ptr_inc;

  // Key storage.
  logic [NUM_ROWS-1:0] raw_r [NUM_COLUMNS];
  logic [CNT_W-1:0]    cnt_mem [NK];
  logic [NK-1:0]       cnt_vld_r;
  logic [NK-1:0]       deb_r;
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                rd_vld_r;
  logic                deb_old_r;

  // Update logic.
  logic [CNT_W-1:0]    cur_cnt, new_cnt;
  logic                samp, deb_old, deb_new;

  // Pending press and result register.
  logic                pend_vld_r;
  logic [CW-1:0]       pend_col_r;
  logic [RW-1:0]       pend_row_r;
  logic                out_valid_r;
  logic [CW-1:0]       out_next_col_r;
  logic                out_press_vld_r;
  logic [CW-1:0]       out_col_r;
  logic [RW-1:0]       out_row_r;
  logic                out_last_r;
  logic                out_free;

  // The pointer steps through the columns and wraps.
  assign ptr_inc = (ptr_r == CW'(NUM_COLUMNS - 1)) ? '0 : ptr_r + CW'(1);

  // Saturating up/down count; a never-written counter reads as zero.
  always_comb begin
    cur_cnt = rd_vld_r ? rd_cnt_r : '0;
    samp    = raw_r[key_col][key_row];
    deb_old = deb_old_r;
    if (samp) begin
      new_cnt = (cur_cnt >= lim_r) ? lim_r : cur_cnt + CNT_W'(1);
    end else begin
      new_cnt = (cur_cnt == '0) ? '0 : cur_cnt - CNT_W'(1);
    end
    // Clearing at zero wins over setting at the limit.
    if (new_cnt == '0) begin
      deb_new = 1'b0;
    end else if (new_cnt == lim_r) begin
      deb_new = 1'b1;
    end else begin
      deb_new = deb_old;
    end
  end

  assign out_free     = !out_valid_r || !out_stall;
  assign sts.rise     = deb_new && !deb_old;
  assign sts.pend_vld = pend_vld_r;
  assign sts.out_free = out_free;

  // Counter memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_cnt_r <= cnt_mem[key_idx];
    end
    if (cmd.commit) begin
      cnt_mem[key_idx] <= new_cnt;
    end
  end

  // Raw samples of each column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        raw_r[c] <= '0;
      end
    end else if (cmd.accept) begin
      raw_r[ptr_inc] <= in_row_levels;
    end
  end

  // Control state: limit, pointer, valid and debounced bits, pending press.
  // The selected key's valid and debounced bits are read in the same cycle
  // as its counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r      <= kmd_pkg::LIMIT_RST;
      ptr_r      <= '0;
      cnt_vld_r  <= '0;
      deb_r      <= '0;
      rd_vld_r   <= 1'b0;
      deb_old_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_limit;
      end
      if (cmd.accept) begin
        ptr_r <= ptr_inc;
      end
      if (cmd.rd) begin
        rd_vld_r  <= cnt_vld_r[key_idx];
        deb_old_r <= deb_r[key_idx];
      end
      if (cmd.commit) begin
        cnt_vld_r[key_idx] <= 1'b1;
        deb_r[key_idx]     <= deb_new;
        if (sts.rise) begin
          pend_vld_r <= 1'b1;
        end
      end
      if (cmd.emit_final) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // Pending press position.
  always_ff @(posedge clk) begin
    if (cmd.commit && sts.rise) begin
      pend_col_r <= key_col;
      pend_row_r <= key_row;
    end
  end

  // Result register: a press goes out once the next one is known, so the
  // closing beat of a tick can carry the last flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pend || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pend) begin
      out_next_col_r  <= ptr_inc;
      out_press_vld_r <= 1'b1;
      out_col_r       <= pend_col_r;
      out_row_r       <= pend_row_r;
      out_last_r      <= 1'b0;
    end else if (cmd.emit_final) begin
      out_next_col_r  <= ptr_inc;
      out_press_vld_r <= pend_vld_r;
      out_col_r       <= pend_vld_r ? pend_col_r : '0;
      out_row_r       <= pend_vld_r ? pend_row_r : '0;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_column  = out_next_col_r;
  assign out_press_valid  = out_press_vld_r;
  assign out_press_column = out_col_r;
  assign out_press_row    = out_row_r;
  assign out_last         = out_last_r;

endmodule

FILE: rtl/keypad_matrix_debounce_scanner.sv
// Top level of the keypad matrix debounce scanner.
// Joins the controller and the datapath. Depends on kmd_pkg, kmd_ctrl and
// kmd_dpath.
//
//   Channel  Handshake          Beat contents
//   in       in_valid/in_stall  in_row_levels
//   out      out_valid/out_stall out_next_column, out_press_valid,
//                               out_press_column, out_press_row, out_last
//   cfg      cfg_valid/cfg_ready cfg_debounce_limit
//
// Each key's counter is read from the single-port counter memory in S_READ
// and updated in S_UPD, so the keys are walked one at a time.
// Reset clears samples and debounced states directly and marks every counter
// as unwritten through valid bits, so there is no clearing pass. Stalls on the
// result side add cycles only when a second or later press of a tick or the
// closing beat finds the result register full.
module keypad_matrix_debounce_scanner #(
  parameter int NUM_COLUMNS = kmd_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = kmd_pkg::NUM_ROWS_DEF,
  localparam int NK = NUM_COLUMNS * NUM_ROWS,
  localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1,
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
  localparam int KW = (NK > 1) ? $clog2(NK) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [NUM_ROWS-1:0]       in_row_levels,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CW-1:0]             out_next_column,
  output logic                      out_press_valid,
  output logic [CW-1:0]             out_press_column,
  output logic [RW-1:0]             out_press_row,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kmd_pkg::CNT_W-1:0] cfg_debounce_limit
);

  kmd_pkg::cmd_t cmd;
  kmd_pkg::sts_t sts;
  logic [CW-1:0] key_col;
  logic [RW-1:0] key_row;
  logic [KW-1:0] key_idx;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  kmd_ctrl #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .key_col  (key_col),
    .key_row  (key_row),
    .key_idx  (key_idx)
  );

  kmd_dpath #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .key_col          (key_col),
    .key_row          (key_row),
    .key_idx          (key_idx),
    .in_row_levels    (in_row_levels),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_limit        (cfg_debounce_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_column  (out_next_column),
    .out_press_valid  (out_press_valid),
    .out_press_column (out_press_column),
    .out_press_row    (out_press_row),
    .out_last         (out_last)
  );

endmodule

FILE: tb/tb_keypad_matrix_debounce_scanner.sv
// Self-checking testbench for keypad_matrix_debounce_scanner.
// Drives scan ticks and debounce limits, predicts every result beat, and
// compares it field by field. Depends on kmd_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module tb_keypad_matrix_debounce_scanner;

  localparam int NCOL = 6;
  localparam int NROW = 6;
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES = 600;   // long result hold-off
  localparam int CFG_SETTLE  = 80;
  localparam int END_SETTLE  = 100;
  localparam int N_PHASES    = 7;
  localparam int HOLD_PHASE  = 4;

  typedef enum {STEP_TICK, STEP_CFG} step_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0] nxt_col;
    logic       press;
    logic [2:0] col;
    logic [2:0] row;
    logic       fin;
  } scan_beat_t;

  typedef struct {
    step_kind_t kind;
    logic [7:0] val;
    bit         typed;    // expected beat given below instead of predicted
    logic [2:0] nxt_col;
  } dir_step_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [NROW-1:0]           in_row_levels;
  logic                      out_valid;
  logic                      out_stall;
  logic [2:0]                out_next_column;
  logic                      out_press_valid;
  logic [2:0]                out_press_column;
  logic [2:0]                out_press_row;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [kmd_pkg::CNT_W-1:0] cfg_debounce_limit;

  // Scanner state as the testbench sees it.
  logic [7:0] limit_q;
  logic [2:0] col_ptr;
  logic       raw_q    [NCOL][NROW];
  logic [7:0] cnt_q    [NCOL][NROW];
  logic       deb_q    [NCOL][NROW];
  logic       deb_prev [NCOL][NROW];

  scan_beat_t press_q[$];     // beats still owed by the scanner
  scan_beat_t tick_beats[$];  // beats caused by the latest tick

  int n_errors;
  int n_ticks;
  int n_beats;
  int n_presses;
  int n_limits;
  int quiet;
  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // Hand-written opening sequence: reset, limit of zero, all 36 keys at once,
  // and a limit lowered while counters sit above it.
  dir_step_t dir_steps [25] = '{
    '{STEP_TICK, 8'h00, 1'b1, 3'd2},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd3},
    '{STEP_TICK, 8'h01, 1'b1, 3'd4},
    '{STEP_CFG,  8'd0,  1'b0, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd5},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd1},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd2},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd3},
    '{STEP_TICK, 8'h3F, 1'b1, 3'd4},
    '{STEP_CFG,  8'd1,  1'b0, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_TICK, 8'h00, 1'b0, 3'd0},
    '{STEP_CFG,  8'd255, 1'b0, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b0, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b0, 3'd0},
    '{STEP_TICK, 8'h3F, 1'b0, 3'd0},
    '{STEP_CFG,  8'd2,  1'b0, 3'd0},
    '{STEP_TICK, 8'h2A, 1'b0, 3'd0},
    '{STEP_TICK, 8'h15, 1'b0, 3'd0}
  };

  // Random phases; a negative limit picks one from 1 to 8.
  int         phase_lim  [N_PHASES] = '{3, 1, 4, -1, 2, 255, 6};
  int         phase_len  [N_PHASES] = '{60, 50, 55, 50, 45, 45, 60};
  idle_mode_t phase_mode [N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                        IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER,
                                        IDLE_BOTH};

  keypad_matrix_debounce_scanner u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_row_levels      (in_row_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_column    (out_next_column),
    .out_press_valid    (out_press_valid),
    .out_press_column   (out_press_column),
    .out_press_row      (out_press_row),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_debounce_limit (cfg_debounce_limit)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clear the predicted scanner state to its reset values.
  task automatic clear_scan_state();
    limit_q = kmd_pkg::LIMIT_RST;
    col_ptr = '0;
    for (int c = 0; c < NCOL; c++) begin
      for (int r = 0; r < NROW; r++) begin
        raw_q[c][r]    = 1'b0;
        cnt_q[c][r]    = '0;
        deb_q[c][r]    = 1'b0;
        deb_prev[c][r] = 1'b0;
      end
    end
  endtask

  // One scan tick: store the column's levels, run every key's integrating
  // counter, and collect the press beats in column-major order.
  task automatic scan_tick(input logic [NROW-1:0] levels);
    scan_beat_t held_beat;
    bit         have;
    logic [7:0] k;
    logic [2:0] nxt;
    have = 1'b0;
    col_ptr = (col_ptr == NCOL - 1) ? 3'd0 : col_ptr + 3'd1;
    for (int r = 0; r < NROW; r++) raw_q[col_ptr][r] = levels[r];
    for (int c = 0; c < NCOL; c++) begin
      for (int r = 0; r < NROW; r++) begin
        k = cnt_q[c][r];
        if (raw_q[c][r]) k = (k >= limit_q) ? limit_q : k + 8'd1;
        else k = (k == 0) ? 8'd0 : k - 8'd1;
        cnt_q[c][r] = k;
        // With a limit of zero both apply and the key stays released.
        if (k == limit_q) deb_q[c][r] = 1'b1;
        if (k == 0) deb_q[c][r] = 1'b0;
      end
    end
    nxt = (col_ptr == NCOL - 1) ? 3'd0 : col_ptr + 3'd1;
    tick_beats.delete();
    for (int c = 0; c < NCOL; c++) begin
      for (int r = 0; r < NROW; r++) begin
        if (deb_q[c][r] && !deb_prev[c][r]) begin
          if (have) tick_beats.push_back(held_beat);
          held_beat = '{nxt, 1'b1, 3'(c), 3'(r), 1'b0};
          have = 1'b1;
        end
        deb_prev[c][r] = deb_q[c][r];
      end
    end
    if (have) begin
      held_beat.fin = 1'b1;
      tick_beats.push_back(held_beat);
    end else begin
      tick_beats.push_back('{nxt, 1'b0, 3'd0, 3'd0, 1'b1});
    end
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 81;
        recv_stall_pct  = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 81;
      end
      default: begin
        sender_idle_pct = 29;
        recv_stall_pct  = 29;
      end
    endcase
  endtask

  // Offer one tick beat; called and returning just after a falling edge.
  task automatic send_tick(input logic [NROW-1:0] levels, input bit typed,
                           input logic [2:0] nxt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid      = 1'b0;
      in_row_levels = NROW'($urandom);
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_row_levels = levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_tick(levels);
    n_ticks++;
    if (typed) press_q.push_back('{nxt, 1'b0, 3'd0, 3'd0, 1'b1});
    else foreach (tick_beats[i]) press_q.push_back(tick_beats[i]);
    @(negedge clk);
  endtask

  // Write the debounce limit once the scanner has delivered everything.
  task automatic set_limit(input logic [7:0] lim);
    in_valid = 1'b0;
    while (press_q.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_valid          = 1'b1;
    cfg_debounce_limit = lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_q = lim;
    n_limits++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check each result beat against the oldest expectation, and watch for
  // a scanner that has gone quiet.
  always @(posedge clk) begin
    scan_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (press_q.size() == 0) begin
        n_errors++;
        $error("result beat with nothing expected");
      end else begin
        want = press_q.pop_front();
        check_field("next_column", want.nxt_col, out_next_column);
        check_field("press_valid", want.press, out_press_valid);
        check_field("press_column", want.col, out_press_column);
        check_field("press_row", want.row, out_press_row);
        check_field("last", want.fin, out_last);
        n_beats++;
        if (out_press_valid) n_presses++;
      end
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [NROW-1:0] held [NCOL];
    logic [NROW-1:0] lv;
    int              nc;
    int              lim;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_row_levels      = '0;
    cfg_valid          = 1'b0;
    cfg_debounce_limit = '0;
    hold_req           = 1'b0;
    n_errors           = 0;
    n_ticks            = 0;
    n_beats            = 0;
    n_presses          = 0;
    n_limits           = 0;
    quiet              = 0;
    for (int c = 0; c < NCOL; c++) held[c] = '0;
    set_idle(IDLE_NONE);
    clear_scan_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening sequence.
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) set_limit(dir_steps[i].val);
      else send_tick(dir_steps[i].val[NROW-1:0], dir_steps[i].typed,
                     dir_steps[i].nxt_col);
    end

    // Random phases: a slowly changing key matrix scanned column by column,
    // with contact bounce and some pure noise mixed in.
    for (int p = 0; p < N_PHASES; p++) begin
      lim = (phase_lim[p] < 0) ? $urandom_range(8, 1) : phase_lim[p];
      set_limit(lim[7:0]);
      set_idle(phase_mode[p]);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < phase_len[p]; i++) begin
        if ($urandom_range(5) == 0) begin
          nc = $urandom_range(NCOL - 1);
          lv = held[nc];
          lv[$urandom_range(NROW - 1)] ^= 1'b1;
          held[nc] = lv;
        end
        nc = (col_ptr == NCOL - 1) ? 0 : col_ptr + 1;
        lv = held[nc];
        if ($urandom_range(9) == 0) lv = NROW'($urandom);
        else if ($urandom_range(7) == 0) lv[$urandom_range(NROW - 1)] ^= 1'b1;
        send_tick(lv, 1'b0, 3'd0);
      end
    end
    in_valid = 1'b0;

    while (press_q.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    $display("Scanned %0d ticks over %0d debounce limit writes;", n_ticks, n_limits);
    $display("checked %0d result beats, %0d of them key presses.", n_beats, n_presses);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
